// File: rtl/lcd4_pkg.sv
package lcd4_pkg;

    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_CMD    = 3'd1,
        ACT_DATA   = 3'd2,
        ACT_CURSOR = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [1:0] DDRAM_SET   = 2'b10;
    localparam logic [2:0] LAST_PHASE  = 3'd4;
    localparam logic [1:0] BYTE_PHASE  = 2'd3;
    localparam logic [2:0] LAST_CMD    = 3'd5;

    // init command bytes, in send order
    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h33;
            3'd1:    v = 8'h32;
            3'd2:    v = 8'h28;
            3'd3:    v = 8'h0C;
            3'd4:    v = 8'h01;
            3'd5:    v = 8'h06;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // settle time after each init command, in us
    function automatic logic [15:0] init_wait(input logic [2:0] idx);
        logic [15:0] v;
        case (idx)
            3'd0:    v = 16'd4100;
            3'd1:    v = 16'd100;
            3'd2:    v = 16'd100;
            3'd3:    v = 16'd100;
            3'd4:    v = 16'd2000;
            3'd5:    v = 16'd2000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/char_lcd_four_bit_interface_unit.sv
// Character LCD controller for a 4-bit HD44780-style bus. Each request transfer
// (init, command byte, data byte, set cursor or clear) is expanded into a run of
// pin-state results: RS, E, the D4..D7 nibble and how many microseconds that
// state is to be held, with last set on the final result of the request. A byte
// goes out as four results (high nibble with E high then low, then the low nibble
// the same way), each held for PULSE_US. Init gives 31 results: a POWERUP_US wait
// keeping the previously driven RS and data levels, then six commands each
// followed by its settle wait. A phase sequencer emits one result per cycle while
// the output register is free; the input is not ready until the last result of
// a request has been loaded into the output register. Actions 5 to 7 are taken
// and dropped with no result.
module char_lcd_four_bit_interface_unit
    import lcd4_pkg::*;
#(
    parameter int PULSE_US   = 1000,
    parameter int POWERUP_US = 15000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_byte_value,
    input  logic [5:0]  i_column,
    input  logic        i_row,
    // pin-state channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_reg_select,
    output logic        o_enable,
    output logic [3:0]  o_nibble,
    output logic [15:0] o_hold_us,
    output logic        o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POWERUP,
        S_RUN
    } t_state;

    localparam logic [15:0] PULSE_HOLD   = 16'(PULSE_US);
    localparam logic [15:0] POWERUP_HOLD = 16'(POWERUP_US);

    // sequencer state
    t_state      r_state,  n_state;
    logic        r_init,   n_init;     // running the init sequence
    logic [2:0]  r_phase,  n_phase;    // 0..3 nibble strobes, 4 settle wait
    logic [2:0]  r_cmd,    n_cmd;      // init command index
    logic [7:0]  r_byte,   n_byte;     // byte of a single-byte request
    logic        r_rs_req, n_rs_req;   // rs of a single-byte request

    // levels now driven on the pins
    logic        r_rs,     n_rs;
    logic [3:0]  r_nib,    n_nib;

    // output register
    logic        r_out_valid, n_out_valid;
    logic        r_out_rs,    n_out_rs;
    logic        r_out_en,    n_out_en;
    logic [3:0]  r_out_nib,   n_out_nib;
    logic [15:0] r_out_hold,  n_out_hold;
    logic        r_out_last,  n_out_last;

    logic        w_gen;
    logic [7:0]  w_cur_byte;
    logic        w_cur_rs;

    assign o_ready = (r_state == S_IDLE);

    // one result per cycle whenever the output register is empty or draining
    assign w_gen = (r_state != S_IDLE) && (!r_out_valid || i_ready);

    assign w_cur_byte = r_init ? init_cmd(r_cmd) : r_byte;
    assign w_cur_rs   = r_init ? 1'b0 : r_rs_req;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_byte      = r_byte;
        n_rs_req    = r_rs_req;
        n_rs        = r_rs;
        n_nib       = r_nib;
        n_out_valid = r_out_valid;
        n_out_rs    = r_out_rs;
        n_out_en    = r_out_en;
        n_out_nib   = r_out_nib;
        n_out_hold  = r_out_hold;
        n_out_last  = r_out_last;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (r_state == S_IDLE && i_valid) begin
            n_phase  = 3'd0;
            n_cmd    = 3'd0;
            n_init   = 1'b0;
            n_rs_req = 1'b0;
            case (t_action'(i_action))
                ACT_INIT: begin
                    n_init  = 1'b1;
                    n_state = S_POWERUP;
                end
                ACT_CMD: begin
                    n_byte  = i_byte_value;
                    n_state = S_RUN;
                end
                ACT_DATA: begin
                    n_byte   = i_byte_value;
                    n_rs_req = 1'b1;
                    n_state  = S_RUN;
                end
                ACT_CURSOR: begin
                    // 0x80 + column + 0x40 * row; column stays below 64
                    n_byte  = {DDRAM_SET[1], i_row, i_column};
                    n_state = S_RUN;
                end
                ACT_CLEAR: begin
                    n_byte  = CMD_CLEAR;
                    n_state = S_RUN;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end

        if (w_gen) begin
            n_out_valid = 1'b1;
            n_out_last  = 1'b0;
            n_out_en    = 1'b0;
            n_out_hold  = PULSE_HOLD;
            n_out_rs    = r_rs;
            n_out_nib   = r_nib;
            if (r_state == S_POWERUP) begin
                // power-up wait keeps whatever was driven before
                n_out_hold = POWERUP_HOLD;
                n_state    = S_RUN;
            end else begin
                case (r_phase)
                    3'd0: begin
                        n_out_rs  = w_cur_rs;
                        n_out_nib = w_cur_byte[7:4];
                        n_out_en  = 1'b1;
                    end
                    3'd1: begin
                        n_out_rs  = w_cur_rs;
                        n_out_nib = w_cur_byte[7:4];
                    end
                    3'd2: begin
                        n_out_rs  = w_cur_rs;
                        n_out_nib = w_cur_byte[3:0];
                        n_out_en  = 1'b1;
                    end
                    3'd3: begin
                        n_out_rs  = w_cur_rs;
                        n_out_nib = w_cur_byte[3:0];
                    end
                    default: begin
                        // settle wait after an init command
                        n_out_hold = init_wait(r_cmd);
                    end
                endcase
                n_rs  = n_out_rs;
                n_nib = n_out_nib;

                if (r_phase == {1'b0, BYTE_PHASE} && !r_init) begin
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end else if (r_phase == LAST_PHASE) begin
                    n_phase = 3'd0;
                    if (r_cmd == LAST_CMD) begin
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_cmd = r_cmd + 3'd1;
                    end
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init      <= 1'b0;
            r_phase     <= 3'd0;
            r_cmd       <= 3'd0;
            r_rs        <= 1'b0;
            r_nib       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_rs        <= n_rs;
            r_nib       <= n_nib;
            r_out_valid <= n_out_valid;
        end
        r_byte     <= n_byte;
        r_rs_req   <= n_rs_req;
        r_out_rs   <= n_out_rs;
        r_out_en   <= n_out_en;
        r_out_nib  <= n_out_nib;
        r_out_hold <= n_out_hold;
        r_out_last <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_reg_select = r_out_rs;
    assign o_enable     = r_out_en;
    assign o_nibble     = r_out_nib;
    assign o_hold_us    = r_out_hold;
    assign o_last       = r_out_last;

    // a known action always starts a sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_action == ACT_INIT || i_action == ACT_CMD ||
         i_action == ACT_DATA || i_action == ACT_CURSOR || i_action == ACT_CLEAR))
        |=> (r_state != S_IDLE))
        else $error("known action did not start a sequence");

    // strobe states are always held for the pulse time
    a_strobe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_enable) |-> (o_hold_us == PULSE_HOLD))
        else $error("strobe state with wrong hold time");

    // single-byte requests never reach the settle phase
    a_no_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !r_init) |-> (r_phase != LAST_PHASE))
        else $error("settle phase in a single-byte request");

    // init command index stays inside the table
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cmd <= LAST_CMD && r_phase <= LAST_PHASE))
        else $error("sequencer counters out of range");

endmodule

// File: tb/sv/lcd4_tb_pkg.sv
package lcd4_tb_pkg;

    import lcd4_pkg::*;

    // one pin state as seen on the result channel
    typedef struct packed {
        logic        reg_select;
        logic        enable;
        logic [3:0]  nibble;
        logic [15:0] hold_us;
        logic        last;
    } t_pin_state;

    localparam logic [15:0] PULSE_HOLD_US   = 16'd1000;
    localparam logic [15:0] POWERUP_HOLD_US = 16'd15000;
    localparam logic [7:0]  CLEAR_BYTE      = 8'h01;
    localparam logic [7:0]  DDRAM_BASE      = 8'h80;
    localparam logic [7:0]  ROW1_OFFSET     = 8'h40;
    localparam int          INIT_STEPS      = 6;

    // init bytes and their settle times, first entry in the low bits
    localparam logic [8*INIT_STEPS-1:0] INIT_BYTES =
        {8'h06, 8'h01, 8'h0C, 8'h28, 8'h32, 8'h33};
    localparam logic [16*INIT_STEPS-1:0] INIT_SETTLE_US =
        {16'd2000, 16'd2000, 16'd100, 16'd100, 16'd100, 16'd4100};

    class lcd_pin_scoreboard;

        t_pin_state  pin_queue[$];
        t_pin_state  burst[$];
        logic        rs_now;
        logic [3:0]  nibble_now;
        int          errors;

        function new();
            rs_now     = 1'b0;
            nibble_now = 4'h0;
            errors     = 0;
        endfunction

        function void hold_pins(input logic en, input logic [15:0] hold);
            t_pin_state p;
            p.reg_select = rs_now;
            p.enable     = en;
            p.nibble     = nibble_now;
            p.hold_us    = hold;
            p.last       = 1'b0;
            burst.push_back(p);
        endfunction

        // high nibble first, each with an E pulse
        function void write_byte(input logic rs, input logic [7:0] value);
            rs_now     = rs;
            nibble_now = value[7:4];
            hold_pins(1'b1, PULSE_HOLD_US);
            hold_pins(1'b0, PULSE_HOLD_US);
            nibble_now = value[3:0];
            hold_pins(1'b1, PULSE_HOLD_US);
            hold_pins(1'b0, PULSE_HOLD_US);
        endfunction

        function void note_request(input logic [2:0] action, input logic [7:0] byte_value,
                                   input logic [5:0] column, input logic row);
            logic [7:0] addr;
            t_pin_state p;
            burst.delete();
            case (action)
                ACT_INIT: begin
                    hold_pins(1'b0, POWERUP_HOLD_US);
                    for (int i = 0; i < INIT_STEPS; i++) begin
                        write_byte(1'b0, INIT_BYTES[i*8 +: 8]);
                        hold_pins(1'b0, INIT_SETTLE_US[i*16 +: 16]);
                    end
                end
                ACT_CMD:  write_byte(1'b0, byte_value);
                ACT_DATA: write_byte(1'b1, byte_value);
                ACT_CURSOR: begin
                    addr = DDRAM_BASE + {2'b00, column} + (row ? ROW1_OFFSET : 8'h00);
                    write_byte(1'b0, addr);
                end
                ACT_CLEAR: write_byte(1'b0, CLEAR_BYTE);
                default: ;
            endcase
            if (burst.size() > 0) begin
                p = burst.pop_back();
                p.last = 1'b1;
                burst.push_back(p);
            end
            foreach (burst[i]) pin_queue.push_back(burst[i]);
        endfunction

        task report(input string what, input logic [15:0] exp, input logic [15:0] got);
            $display("%0t ns pin-state mismatch: %s expected %0h got %0h",
                     $time, what, exp, got);
            errors++;
        endtask

        task check_result(input logic rs, input logic en, input logic [3:0] nib,
                          input logic [15:0] hold, input logic last);
            t_pin_state exp;
            if (pin_queue.size() == 0) begin
                report("unexpected transfer, hold_us", 16'h0, hold);
            end else begin
                exp = pin_queue.pop_front();
                if (rs !== exp.reg_select)
                    report("reg_select", 16'(exp.reg_select), 16'(rs));
                if (en !== exp.enable)
                    report("enable", 16'(exp.enable), 16'(en));
                if (nib !== exp.nibble)
                    report("nibble", 16'(exp.nibble), 16'(nib));
                if (hold !== exp.hold_us)
                    report("hold_us", exp.hold_us, hold);
                if (last !== exp.last)
                    report("last", 16'(exp.last), 16'(last));
            end
        endtask

        function int pending();
            return pin_queue.size();
        endfunction

    endclass

endpackage

// File: tb/sv/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lcd4_pkg::*;
    import lcd4_tb_pkg::*;

    // cycles with no transfer on either channel before the run is abandoned
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 44;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_action = 3'd0;
    logic [7:0]  i_byte_value = 8'h00;
    logic [5:0]  i_column = 6'd0;
    logic        i_row = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_reg_select;
    logic        o_enable;
    logic [3:0]  o_nibble;
    logic [15:0] o_hold_us;
    logic        o_last;

    // percentages of idle cycles on each side, changed per phase
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int stall_cycles  = 0;

    lcd_pin_scoreboard sb = new();

    char_lcd_four_bit_interface_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_reg_select (o_reg_select),
        .o_enable     (o_enable),
        .o_nibble     (o_nibble),
        .o_hold_us    (o_hold_us),
        .o_last       (o_last)
    );

    always #4 i_clk = ~i_clk;

    // result side back-pressure, random per cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // monitor: results are checked before a request transfer on the same edge is noted,
    // a request can never produce a result on the edge it is taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result(o_reg_select, o_enable, o_nibble, o_hold_us, o_last);
            end
            if (i_valid && o_ready) begin
                sb.note_request(i_action, i_byte_value, i_column, i_row);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
        end
        $display("[char_lcd_four_bit_interface_unit] ERROR");
        $finish;
    end

    // one request transfer; returns on the edge where it is taken, so the caller's
    // next assignment to i_valid lands in that same step only once
    task send_request(input logic [2:0] action, input logic [7:0] byte_value,
                      input logic [5:0] column, input logic row);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= action;
        i_byte_value <= byte_value;
        i_column     <= column;
        i_row        <= row;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // random requests, weighted towards byte traffic; ignored actions do not count
    task send_random_phase(input int count);
        int sent;
        int pick;
        logic [2:0] action;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       action = ACT_INIT;
            else if (pick < 30) action = ACT_CMD;
            else if (pick < 58) action = ACT_DATA;
            else if (pick < 80) action = ACT_CURSOR;
            else if (pick < 93) action = ACT_CLEAR;
            else                action = 3'($urandom_range(5, 7));
            send_request(action, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
            if (action <= ACT_CLEAR) sent++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        // init straight after reset: power-up wait keeps the reset pin levels
        send_request(ACT_INIT, 8'h00, 6'd0, 1'b0);
        send_request(ACT_CMD, 8'h00, 6'd0, 1'b0);
        send_request(ACT_CMD, 8'hFF, 6'd63, 1'b1);
        send_request(ACT_DATA, 8'h00, 6'd0, 1'b0);
        send_request(ACT_DATA, 8'hFF, 6'd0, 1'b0);
        send_request(ACT_DATA, 8'hA5, 6'd0, 1'b0);
        // init after a data byte: power-up wait holds RS high and the last nibble
        send_request(ACT_INIT, 8'hFF, 6'd63, 1'b1);
        send_request(ACT_CURSOR, 8'h00, 6'd0, 1'b0);
        send_request(ACT_CURSOR, 8'h00, 6'd0, 1'b1);
        send_request(ACT_CURSOR, 8'h00, 6'd39, 1'b1);
        // widest column on both rows, address still fits a byte
        send_request(ACT_CURSOR, 8'h00, 6'd63, 1'b0);
        send_request(ACT_CURSOR, 8'h00, 6'd63, 1'b1);
        send_request(ACT_CLEAR, 8'hFF, 6'd63, 1'b1);
        // unknown actions are dropped without results or state change
        send_request(3'd5, 8'h3C, 6'd21, 1'b1);
        send_request(3'd6, 8'hC3, 6'd42, 1'b0);
        send_request(3'd7, 8'hFF, 6'd63, 1'b1);
        send_request(ACT_INIT, 8'h00, 6'd0, 1'b0);
        send_request(ACT_DATA, 8'h5A, 6'd0, 1'b0);
        send_request(ACT_CMD, 8'h96, 6'd0, 1'b0);
        send_request(ACT_DATA, 8'h01, 6'd0, 1'b0);
        send_request(ACT_CLEAR, 8'h00, 6'd0, 1'b0);

        // random part over the idling phases
        send_random_phase(PHASE_ITEMS);
        src_idle_pct   = 76;
        sink_stall_pct = 0;
        send_random_phase(PHASE_ITEMS);
        src_idle_pct   = 0;
        sink_stall_pct = 76;
        send_random_phase(PHASE_ITEMS);
        src_idle_pct   = 36;
        sink_stall_pct = 36;
        send_random_phase(PHASE_ITEMS);
        i_valid <= 1'b0;

        // drain, then watch for stray results
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("[char_lcd_four_bit_interface_unit] OK");
        end else begin
            $display("[char_lcd_four_bit_interface_unit] ERROR");
        end
        $finish;
    end

endmodule
